### design/bfl_pkg.sv
// shared types and constants of the buffer free list
package bfl_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int BLOCK_BITS = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam int IN_W  = 24;
    localparam int OUT_W = 32;

    typedef logic [BLOCK_BITS-1:0] t_blk;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef struct packed {
        t_blk blk;
        logic hq;
        logic dw;
    } t_entry;

    typedef enum logic [2:0] {
        ACT_APPEND    = 3'd0,
        ACT_PUSH_HEAD = 3'd1,
        ACT_POP       = 3'd2,
        ACT_REMOVE    = 3'd3,
        ACT_SEARCH    = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_APPEND,
        CMD_PUSH_HEAD,
        CMD_SHIFT_DROP,
        CMD_ROTATE
    } t_cell_cmd;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        t_cell_cmd cmd;
        t_cnt      count;
        t_entry    new_entry;
    } t_cell_ctl;

    typedef struct packed {
        logic [6:0]  free_count;
        logic        dw;
        logic        hq;
        logic [15:0] blk;
        t_status     status;
    } t_result;

endpackage

### design/bfl_cell.sv
// one list cell: holds a single entry and moves it to or from its neighbors
module bfl_cell import bfl_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_cnt      i_index,
    input  t_entry    i_left,
    input  t_entry    i_right,
    input  t_entry    i_head,
    output t_entry    o_entry
);

    t_entry r_entry;
    t_entry n_entry;
    t_cnt   tail_idx;

    assign tail_idx = CNT_W'(i_ctl.count - 1'b1);

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.cmd)
            CMD_APPEND: begin
                if (i_index == i_ctl.count) begin
                    n_entry = i_ctl.new_entry;
                end
            end
            CMD_PUSH_HEAD: begin
                n_entry = (i_index == '0) ? i_ctl.new_entry : i_left;
            end
            CMD_SHIFT_DROP: begin
                n_entry = i_right;
            end
            CMD_ROTATE: begin
                // the tail cell takes the old head, the rest move toward the head
                n_entry = (i_index == tail_idx) ? i_head : i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

### design/bfl_ctrl.sv
// request decode, scan sequencer, entry count and result register
module bfl_ctrl import bfl_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [IN_W-1:0] s_axis_tdata,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output t_result         o_result,
    input  t_entry          i_head,
    output t_cell_ctl       o_ctl
);

    t_state  r_state, n_state;
    t_cnt    r_count, n_count;
    t_cnt    r_left, n_left;
    t_blk    r_key, n_key;
    logic    r_remove, n_remove;
    logic    r_found, n_found;
    t_entry  r_hit, n_hit;
    logic    r_ovalid;
    t_result r_res;

    t_result res;
    logic    load_res;
    logic    in_fire;
    logic    out_free;
    logic    match;
    t_action action;
    t_entry  in_entry;

    assign action       = t_action'(s_axis_tdata[2:0]);
    assign in_entry.blk = BLOCK_BITS'(s_axis_tdata[18:3]);
    assign in_entry.hq  = s_axis_tdata[19];
    assign in_entry.dw  = s_axis_tdata[20];

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_left    = r_left;
        n_key     = r_key;
        n_remove  = r_remove;
        n_found   = r_found;
        n_hit     = r_hit;
        o_ctl.cmd       = CMD_HOLD;
        o_ctl.count     = r_count;
        o_ctl.new_entry = in_entry;
        res       = '0;
        load_res  = 1'b0;
        match     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (action)
                        ACT_APPEND, ACT_PUSH_HEAD: begin
                            load_res = 1'b1;
                            if (r_count == CNT_W'(LIST_DEPTH)) begin
                                res.status = STAT_FULL;
                            end else begin
                                o_ctl.cmd = (action == ACT_APPEND) ? CMD_APPEND
                                                                   : CMD_PUSH_HEAD;
                                n_count = CNT_W'(r_count + 1'b1);
                            end
                        end
                        ACT_POP: begin
                            load_res = 1'b1;
                            if (r_count == '0) begin
                                res.status = STAT_EMPTY;
                            end else begin
                                res.blk   = 16'(i_head.blk);
                                res.hq    = i_head.hq;
                                res.dw    = i_head.dw;
                                o_ctl.cmd = CMD_SHIFT_DROP;
                                n_count   = CNT_W'(r_count - 1'b1);
                            end
                        end
                        ACT_REMOVE, ACT_SEARCH: begin
                            if (r_count == '0) begin
                                load_res   = 1'b1;
                                res.status = STAT_NOT_FOUND;
                            end else begin
                                n_state  = S_SCAN;
                                n_left   = r_count;
                                n_key    = in_entry.blk;
                                n_remove = (action == ACT_REMOVE);
                                n_found  = 1'b0;
                            end
                        end
                        default: begin
                            load_res = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_left != '0) begin
                    // one original entry reaches the head per cycle
                    match = !r_found && (i_head.blk == r_key);
                    if (match) begin
                        n_found = 1'b1;
                        n_hit   = i_head;
                    end
                    if (match && r_remove) begin
                        o_ctl.cmd = CMD_SHIFT_DROP;
                        n_count   = CNT_W'(r_count - 1'b1);
                    end else begin
                        o_ctl.cmd = CMD_ROTATE;
                    end
                    n_left = CNT_W'(r_left - 1'b1);
                end else if (out_free) begin
                    load_res = 1'b1;
                    n_state  = S_IDLE;
                    if (r_found) begin
                        res.blk = 16'(r_hit.blk);
                        res.hq  = r_hit.hq;
                        res.dw  = r_hit.dw;
                    end else begin
                        res.status = STAT_NOT_FOUND;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        res.free_count = 7'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_res) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_key    <= n_key;
        r_remove <= n_remove;
        r_found  <= n_found;
        r_hit    <= n_hit;
        if (load_res) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign o_result      = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LIST_DEPTH))
        else $error("entry count above list depth");

    a_no_accept_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !s_axis_tready)
        else $error("request accepted during a scan");

    a_single_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_found) |=> $stable(r_count))
        else $error("scan dropped more than one entry");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_left <= r_count))
        else $error("scan steps exceed entry count");

endmodule

### design/buffer_free_list.sv
// top level of the buffer free list: controller and a row of entry cells
//
// ordered free list of up to LIST_DEPTH buffer-cache entries (block number,
// hash-queue flag, delayed-write flag), cell 0 being the head. append, insert
// at head and pop need no walk: every cell loads, shifts toward the tail or
// shifts toward the head in parallel. remove-by-block and search walk the
// list: in each cycle the head entry is compared against the key and then
// either recirculated to the tail cell or, for the first hit of a remove,
// dropped, so after entry_count steps the list is back in order. such a
// request passes through the accept cycle, one step per entry of the
// one-entry-per-cycle rotation through the cell row, and a result load that
// waits for a free output register; others load theirs when accepted. exactly
// one result word comes back per request word; a result waits in an output
// register and a new request is taken while it is being read out. no clearing
// pass after reset: only cells below the entry count are ever read
module buffer_free_list import bfl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // action[2:0], block_number[18:3], in_hash_queue[19], delay_flag[20]
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status[1:0], out_block[17:2], out_in_hash_queue[18],
    // out_delay_flag[19], free_count[26:20]
    output logic [OUT_W-1:0] m_axis_tdata
);

    t_cell_ctl ctl;
    t_result   result;
    t_entry    cell_q [LIST_DEPTH];

    bfl_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_result      (result),
        .i_head        (cell_q[0]),
        .o_ctl         (ctl)
    );

    // row of cells; the ends take harmless neighbors
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        t_entry left_n;
        t_entry right_n;

        if (g == 0) begin : g_first
            assign left_n = ctl.new_entry;
        end else begin : g_mid_l
            assign left_n = cell_q[g-1];
        end

        if (g == LIST_DEPTH - 1) begin : g_last
            assign right_n = cell_q[g];
        end else begin : g_mid_r
            assign right_n = cell_q[g+1];
        end

        bfl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_index (CNT_W'(g)),
            .i_left  (left_n),
            .i_right (right_n),
            .i_head  (cell_q[0]),
            .o_entry (cell_q[g])
        );
    end

    // result word packed from the lowest bit up, zero filled
    assign m_axis_tdata = OUT_W'(result);

endmodule
